>>> rtl/vmwd_pkg.sv
// ----------------------------------------------------------------------------
// vmwd_pkg: shared definitions for the vector-mean wind direction block
// Holds widths, the quarter-wave sine table, the arctangent table, the
// quadrant lookup function and the state and control types.
// ----------------------------------------------------------------------------
package vmwd_pkg;

   localparam int MAX_SAMPLES  = 128;
   localparam int TRIG_BITS    = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W       = $clog2(CORDIC_ITERS);

   localparam int ANGLE_W  = 9;
   localparam int DIR_W    = 9;
   localparam int SUM_W    = 24;
   localparam int COUNT_W  = 8;
   localparam int WANG_W   = 10;
   localparam int QIDX_W   = 7;
   localparam int QENTRIES = 91;
   localparam int XY_W     = 27;
   localparam int Z_W      = 27;
   localparam int DEG_FRAC = 16;

   localparam logic signed [Z_W-1:0] Z_HALF_DEG     = Z_W'(32768);
   localparam logic signed [Z_W-1:0] Z_QUARTER_TURN = Z_W'(90 * 65536);
   localparam logic signed [Z_W-1:0] Z_FULL_TURN    = Z_W'(360 * 65536);

   // Arctangent of 2^-i in Q16 degrees.
   localparam logic signed [Z_W-1:0] ATAN_Q16 [0:ATAN_ENTRIES-1] = '{
      Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
      Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
      Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
      Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
      Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
      Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
   };

   typedef logic [QENTRIES-1:0][TRIG_BITS-1:0] qsine_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT
   } seq_state_type;

   typedef enum logic [1:0] {
      CD_IDLE,
      CD_ITER,
      CD_ROUND
   } cordic_state_type;

   typedef struct packed {
      logic sample;
      logic clear;
   } acc_ctrl_type;

   // Builds the 0..90 degree sine table at elaboration with a 24-step rotation
   // CORDIC in Q30, clamped and scaled to the table amplitude.
   function automatic qsine_type build_qsine();
      qsine_type tbl;
      longint    amp;
      longint    x;
      longint    y;
      longint    z;
      longint    dx;
      longint    dy;
      int        a;
      int        i;
      tbl = '0;
      amp = (longint'(1) <<< (TRIG_BITS - 1)) - 1;
      for (a = 0; a < QENTRIES; a++) begin
         x = 652032874;
         y = 0;
         z = longint'(a) * 65536;
         for (i = 0; i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ATAN_Q16[i]);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ATAN_Q16[i]);
            end
         end
         if (y < 0) y = 0;
         if (y > (longint'(1) <<< 30)) y = longint'(1) <<< 30;
         tbl[a] = TRIG_BITS'((y * amp + (longint'(1) <<< 29)) >>> 30);
      end
      return tbl;
   endfunction

   localparam qsine_type QSINE = build_qsine();

   // Sine of a whole-degree angle in 0..359 through quadrant symmetry.
   function automatic logic signed [TRIG_BITS-1:0] sine_lookup(input logic [WANG_W-1:0] ang);
      logic [WANG_W-1:0]          idx;
      logic                       neg;
      logic signed [TRIG_BITS-1:0] mag;
      if (ang <= WANG_W'(90)) begin
         idx = ang;
         neg = 1'b0;
      end else if (ang <= WANG_W'(180)) begin
         idx = WANG_W'(180) - ang;
         neg = 1'b0;
      end else if (ang <= WANG_W'(270)) begin
         idx = ang - WANG_W'(180);
         neg = 1'b1;
      end else begin
         idx = WANG_W'(360) - ang;
         neg = 1'b1;
      end
      mag = signed'(QSINE[idx[QIDX_W-1:0]]);
      return neg ? -mag : mag;
   endfunction

endpackage

>>> rtl/vmwd_accum.sv
// ----------------------------------------------------------------------------
// vmwd_accum: east and north vector accumulators
// Looks up sine and cosine of each sample and adds them into two saturating
// sums, counting samples up to the set limit.
// ----------------------------------------------------------------------------
module vmwd_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vmwd_pkg::acc_ctrl_type               ctrl,
   input  logic [vmwd_pkg::ANGLE_W-1:0]         angle_deg,
   output logic signed [vmwd_pkg::SUM_W-1:0]    east_sum,
   output logic signed [vmwd_pkg::SUM_W-1:0]    north_sum
);
   import vmwd_pkg::*;

   logic signed [SUM_W-1:0]     east_ff, east_in;
   logic signed [SUM_W-1:0]     north_ff, north_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [WANG_W-1:0]           sin_ang;
   logic [WANG_W-1:0]           cos_ang;
   logic signed [TRIG_BITS-1:0] sin_val;
   logic signed [TRIG_BITS-1:0] cos_val;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                       input logic signed [TRIG_BITS-1:0] d);
      logic signed [SUM_W:0] wide;
      wide = (SUM_W+1)'(s) + (SUM_W+1)'(d);
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         return {wide[SUM_W], {(SUM_W-1){~wide[SUM_W]}}};
      end
      return wide[SUM_W-1:0];
   endfunction

   always_comb begin
      if (angle_deg >= ANGLE_W'(360)) begin
         sin_ang = WANG_W'(angle_deg) - WANG_W'(360);
      end else begin
         sin_ang = WANG_W'(angle_deg);
      end
      if (sin_ang + WANG_W'(90) >= WANG_W'(360)) begin
         cos_ang = sin_ang + WANG_W'(90) - WANG_W'(360);
      end else begin
         cos_ang = sin_ang + WANG_W'(90);
      end
      sin_val = sine_lookup(sin_ang);
      cos_val = sine_lookup(cos_ang);
   end

   always_comb begin
      east_in  = east_ff;
      north_in = north_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         east_in  = '0;
         north_in = '0;
         count_in = '0;
      end else if (ctrl.sample && (count_ff < COUNT_W'(MAX_SAMPLES))) begin
         east_in  = sat_add(east_ff, sin_val);
         north_in = sat_add(north_ff, cos_val);
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         east_ff  <= '0;
         north_ff <= '0;
         count_ff <= '0;
      end else begin
         east_ff  <= east_in;
         north_ff <= north_in;
         count_ff <= count_in;
      end
   end

   assign east_sum  = east_ff;
   assign north_sum = north_ff;

endmodule

>>> rtl/vmwd_cordic.sv
// ----------------------------------------------------------------------------
// vmwd_cordic: iterative vectoring CORDIC for atan2 in degrees
// One shift-add stage is reused once per cycle; a final rounding state rounds and
// wraps the angle into whole degrees.
// ----------------------------------------------------------------------------
module vmwd_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [vmwd_pkg::SUM_W-1:0]    east_sum,
   input  logic signed [vmwd_pkg::SUM_W-1:0]    north_sum,
   output logic                                 done,
   output logic [vmwd_pkg::DIR_W-1:0]           direction
);
   import vmwd_pkg::*;

   cordic_state_type        state_ff, state_in;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    neg_east_ff, neg_east_in;
   logic                    done_ff, done_in;
   logic [DIR_W-1:0]        dir_ff, dir_in;

   logic                    both_zero;
   logic signed [XY_W-1:0]  e_ext;
   logic signed [XY_W-1:0]  n_ext;
   logic signed [XY_W-1:0]  dx;
   logic signed [XY_W-1:0]  dy;
   logic signed [Z_W-1:0]   z_round;

   assign both_zero = (east_sum == '0) && (north_sum == '0);
   assign e_ext     = XY_W'(east_sum);
   assign n_ext     = XY_W'(north_sum);
   assign dx        = y_ff >>> step_ff;
   assign dy        = x_ff >>> step_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CD_IDLE: begin
            if (start) begin
               state_in = both_zero ? CD_ROUND : CD_ITER;
            end
         end
         CD_ITER: begin
            if (step_ff == STEP_W'(CORDIC_ITERS - 1)) begin
               state_in = CD_ROUND;
            end
         end
         CD_ROUND: state_in = CD_IDLE;
         default:  state_in = CD_IDLE;
      endcase
   end

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      step_in     = step_ff;
      neg_east_in = neg_east_ff;
      done_in     = 1'b0;
      dir_in      = dir_ff;
      z_round     = z_ff + Z_HALF_DEG + (neg_east_ff ? Z_FULL_TURN : '0);
      case (state_ff)
         CD_IDLE: begin
            if (start) begin
               step_in     = '0;
               neg_east_in = east_sum[SUM_W-1];
               if (both_zero) begin
                  x_in = '0;
                  y_in = '0;
                  z_in = '0;
               end else if (north_sum[SUM_W-1]) begin
                  // Pre-rotate by a quarter turn so the vector lies in the right half plane.
                  if (!east_sum[SUM_W-1]) begin
                     x_in = e_ext;
                     y_in = -n_ext;
                     z_in = Z_QUARTER_TURN;
                  end else begin
                     x_in = -e_ext;
                     y_in = n_ext;
                     z_in = -Z_QUARTER_TURN;
                  end
               end else begin
                  x_in = n_ext;
                  y_in = e_ext;
                  z_in = '0;
               end
            end
         end
         CD_ITER: begin
            if (!y_ff[XY_W-1] && (y_ff != '0)) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + ATAN_Q16[ATAN_IDX_W'(step_ff)];
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - ATAN_Q16[ATAN_IDX_W'(step_ff)];
            end
            step_in = step_ff + STEP_W'(1);
         end
         CD_ROUND: begin
            done_in = 1'b1;
            if ((z_round >= Z_FULL_TURN) || z_round[Z_W-1]) begin
               dir_in = '0;
            end else begin
               dir_in = z_round[DEG_FRAC+DIR_W-1:DEG_FRAC];
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CD_IDLE;
         done_ff     <= 1'b0;
         step_ff     <= '0;
         neg_east_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         done_ff     <= done_in;
         step_ff     <= step_in;
         neg_east_ff <= neg_east_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      dir_ff <= dir_in;
   end

   assign done      = done_ff;
   assign direction = dir_ff;

endmodule

>>> rtl/vector_mean_wind_direction.sv
// ----------------------------------------------------------------------------
// vector_mean_wind_direction: vector-mean wind direction of a sample set
// Accumulates unit vectors of whole-degree samples and reports the rounded
// direction of their sum when the last sample of a set arrives.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted at a rising clock edge with start high and
// busy low; req_angle_deg carries one direction sample (values of 360 and up
// are reduced by 360) and req_last_sample marks the end of a set.
// An ordinary sample is absorbed in the cycle it is accepted, so busy stays
// low and samples may arrive every cycle. Samples past the set limit are
// dropped, though a dropped last sample still closes the set.
// When the last sample is accepted, busy rises and the block computes
// atan2(east, north) with a vectoring CORDIC that does one shift-add step
// per cycle. The result appears on rsp_mean_direction with rsp_valid high
// for exactly one cycle, after the launch state, the CORDIC_ITERS CORDIC
// iterations and a rounding step; the iterations are skipped when both sums
// are zero. busy falls the cycle after the result strobe. The receiver has
// no way to stall the result channel.
// A synchronous reset clears the sums, the sample count and the sequencer.
// ----------------------------------------------------------------------------
module vector_mean_wind_direction (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [vmwd_pkg::ANGLE_W-1:0]      req_angle_deg,
   input  logic                              req_last_sample,
   output logic                              rsp_valid,
   output logic [vmwd_pkg::DIR_W-1:0]        rsp_mean_direction
);
   import vmwd_pkg::*;

   seq_state_type            state_ff, state_in;
   acc_ctrl_type             acc_ctrl;
   logic                     accept;
   logic                     cordic_start;
   logic                     cordic_done;
   logic signed [SUM_W-1:0]  east_sum;
   logic signed [SUM_W-1:0]  north_sum;

   // A transaction is taken only while the sequencer sits idle.
   assign accept = start && (state_ff == ST_IDLE);

   // Next-state logic: a last sample launches the CORDIC in the cycle after it is
   // accepted, after its own contribution has landed in the sums.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_sample) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (cordic_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic: the launch cycle hands the sums to the CORDIC and clears
   // them in the same edge, so the next set starts from zero.
   always_comb begin
      busy            = 1'b1;
      acc_ctrl.sample = 1'b0;
      acc_ctrl.clear  = 1'b0;
      cordic_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy            = 1'b0;
            acc_ctrl.sample = start;
         end
         ST_LAUNCH: begin
            acc_ctrl.clear = 1'b1;
            cordic_start   = 1'b1;
         end
         ST_WAIT: begin
            busy = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   vmwd_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .angle_deg (req_angle_deg),
      .east_sum  (east_sum),
      .north_sum (north_sum)
   );

   vmwd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cordic_start),
      .east_sum  (east_sum),
      .north_sum (north_sum),
      .done      (cordic_done),
      .direction (rsp_mean_direction)
   );

   // The CORDIC's done flag is a registered one-cycle pulse.
   assign rsp_valid = cordic_done;

endmodule
